// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on a rising edge and disabled
// while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/lptd_pkg.sv
// ----------------------------------------------------------------------------
// lptd_pkg
// Types, constants and the rotation angle table of the leading pair
// transverse momentum difference block.
// ----------------------------------------------------------------------------
package lptd_pkg;

    // Item field widths.
    localparam int MOM_W   = 16;
    localparam int AZ_W    = 16;
    localparam int QUAL_W  = 11;
    localparam int DIFF_W  = 17;

    // Configuration port.
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_ELECTRON_CUT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MUON_CUT     = CFG_IDX_W'(1);
    localparam logic [QUAL_W-1:0] ELECTRON_CUT_RESET  = QUAL_W'(512);
    localparam logic [QUAL_W-1:0] MUON_CUT_RESET      = QUAL_W'(614);

    // Fixed-point datapath.
    localparam int FRAC_BITS  = 8;
    localparam int MAG_W      = 24;   // prescaled muon momentum, 8 fraction bits
    localparam int XY_W       = 27;   // signed rotation and difference vector
    localparam int Z_W        = 24;   // signed residual angle, 2^-24 turn units
    localparam int ANG_W      = 14;   // angle within one quadrant
    localparam int ROT_STEPS  = 16;
    localparam int STEP_W     = 4;
    localparam int MUL_W      = XY_W;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int SUM_W      = 52;
    localparam int ROOT_W     = SUM_W / 2;
    localparam int ROOT_CNT_W = 5;
    localparam int LEN_W      = ROOT_W + 1 - FRAC_BITS;

    localparam logic [MUL_W-1:0]  INV_GAIN = MUL_W'(39797);
    localparam logic [DIFF_W-1:0] DIFF_MAX = DIFF_W'(131070);

    typedef struct packed {
        logic              is_muon;
        logic [MOM_W-1:0]  momentum;
        logic [AZ_W-1:0]   azimuth;
        logic [QUAL_W-1:0] quality;
        logic              end_of_event;
    } lptd_in_t;

    typedef struct packed {
        logic [DIFF_W-1:0] momentum_difference;
        logic              defined;
    } lptd_out_t;

    // Start command for the rotation unit.
    typedef struct packed {
        logic             start;
        logic [1:0]       quad;
        logic [MAG_W-1:0] mag;
        logic [ANG_W-1:0] angle;
    } lptd_rot_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE,
        ST_LOAD,
        ST_ROTATE,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SUM,
        ST_ROOT,
        ST_DONE
    } lptd_state_t;

    // Rounded arctangent of 2^-i in 2^-24 turn units.
    function automatic logic signed [Z_W-1:0] lptd_arc(input logic [STEP_W-1:0] idx);
        logic signed [Z_W-1:0] val;
        unique case (idx)
            4'd0:    val = Z_W'(2097152);
            4'd1:    val = Z_W'(1238021);
            4'd2:    val = Z_W'(654136);
            4'd3:    val = Z_W'(332050);
            4'd4:    val = Z_W'(166669);
            4'd5:    val = Z_W'(83416);
            4'd6:    val = Z_W'(41718);
            4'd7:    val = Z_W'(20860);
            4'd8:    val = Z_W'(10430);
            4'd9:    val = Z_W'(5215);
            4'd10:   val = Z_W'(2608);
            4'd11:   val = Z_W'(1304);
            4'd12:   val = Z_W'(652);
            4'd13:   val = Z_W'(326);
            4'd14:   val = Z_W'(163);
            4'd15:   val = Z_W'(81);
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// File: sv/lptd_mul.sv
// ----------------------------------------------------------------------------
// lptd_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module lptd_mul
    import lptd_pkg::*;
(
    input  logic                     aclk,
    input  logic signed [MUL_W-1:0]  op_a,
    input  logic signed [MUL_W-1:0]  op_b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

// File: sv/lptd_cordic.sv
// ----------------------------------------------------------------------------
// lptd_cordic
// Iterative rotation unit: one shift-add rotation step per cycle over a
// fixed number of steps, after an exact quarter-turn preset.
// ----------------------------------------------------------------------------
module lptd_cordic
    import lptd_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  lptd_rot_cmd_t           cmd,
    output logic                    done,
    output logic signed [XY_W-1:0]  x_out,
    output logic signed [XY_W-1:0]  y_out
);

    logic signed [XY_W-1:0] x_reg, x_next;
    logic signed [XY_W-1:0] y_reg, y_next;
    logic signed [Z_W-1:0]  z_reg, z_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic signed [XY_W-1:0] mag_ext;
    logic signed [XY_W-1:0] x_sh;
    logic signed [XY_W-1:0] y_sh;

    assign mag_ext = XY_W'({1'b0, cmd.mag});
    assign x_sh    = x_reg >>> step_reg;
    assign y_sh    = y_reg >>> step_reg;

    always_comb begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (cmd.start) begin
            case (cmd.quad)
                2'd0: begin
                    x_next = mag_ext;
                    y_next = '0;
                end
                2'd1: begin
                    x_next = '0;
                    y_next = mag_ext;
                end
                2'd2: begin
                    x_next = -mag_ext;
                    y_next = '0;
                end
                default: begin
                    x_next = '0;
                    y_next = -mag_ext;
                end
            endcase
            z_next    = Z_W'({cmd.angle, {FRAC_BITS{1'b0}}});
            step_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // A non-negative residual rotates counterclockwise.
            if (!z_reg[Z_W-1]) begin
                x_next = x_reg - y_sh;
                y_next = y_reg + x_sh;
                z_next = z_reg - lptd_arc(step_reg);
            end else begin
                x_next = x_reg + y_sh;
                y_next = y_reg - x_sh;
                z_next = z_reg + lptd_arc(step_reg);
            end
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(ROT_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign done  = done_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;

endmodule

// File: sv/lptd_sqrt.sv
// ----------------------------------------------------------------------------
// lptd_sqrt
// Iterative floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module lptd_sqrt
    import lptd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [SUM_W-1:0]  radicand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    logic [SUM_W-1:0]      rem_reg, rem_next;
    logic [SUM_W-1:0]      res_reg, res_next;
    logic [SUM_W-1:0]      bit_reg, bit_next;
    logic [ROOT_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [SUM_W:0]        trial;

    assign trial = {1'b0, res_reg} + {1'b0, bit_reg};

    always_comb begin
        rem_next  = rem_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = radicand;
            res_next  = '0;
            bit_next  = SUM_W'(1) << (SUM_W - 2);
            cnt_next  = ROOT_CNT_W'(ROOT_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if ({1'b0, rem_reg} >= trial) begin
                rem_next = rem_reg - trial[SUM_W-1:0];
                res_next = (res_reg >> 1) + bit_reg;
            end else begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg - ROOT_CNT_W'(1);
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[ROOT_W-1:0];

endmodule

// File: sv/leading_pair_transverse_diff.sv
// ----------------------------------------------------------------------------
// leading_pair_transverse_diff
// Leading electron and muon per event, and the length of the difference of
// their transverse momentum vectors.
// ----------------------------------------------------------------------------
// Each item is one particle. A particle that passes its kind's quality cut
// (strictly greater) may replace the leading particle of its kind when its
// momentum is strictly higher; the first kept particle of a kind always
// becomes the leader. After an ordinary item the block is ready again at once.
// The item that ends an event produces exactly one result and clears the
// leaders. If the event lacks a kept electron or a kept muon the sequencer
// goes straight to its done state (difference zero, defined low). Otherwise
// the sequencer runs and no item is accepted until it is idle: a prescale on
// the shared multiplier, 16 rotation steps in the CORDIC unit, two squarings
// on the same multiplier and the bit-serial square root. The result waits to
// be taken in an output register while the next event's particles are accepted;
// a later event end is processed but waits in the done state until that
// register is free. Quality cuts are written by the user through the
// configuration port (index 0 electron, 1 muon) only while the block is idle;
// the block does not enforce this. Other indexes are ignored.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module leading_pair_transverse_diff
    import lptd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  lptd_in_t              s_data,

    output logic                  m_valid,
    input  logic                  m_ready,
    output lptd_out_t             m_data,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration registers.
    logic [QUAL_W-1:0] e_cut_reg;
    logic [QUAL_W-1:0] mu_cut_reg;

    // Leading particles of the running event.
    logic [MOM_W-1:0] e_mom_reg,  e_mom_next;
    logic [AZ_W-1:0]  e_az_reg,   e_az_next;
    logic             have_e_reg, have_e_next;
    logic [MOM_W-1:0] mu_mom_reg, mu_mom_next;
    logic [AZ_W-1:0]  mu_az_reg,  mu_az_next;
    logic             have_mu_reg, have_mu_next;

    // Work registers of the event being finished.
    logic [MOM_W-1:0]  w_e_mom_reg;
    logic [MOM_W-1:0]  w_mu_mom_reg;
    logic [AZ_W-1:0]   w_theta_reg;
    logic              w_def_reg;
    logic [SUM_W-1:0]  sum_reg;

    lptd_state_t state_reg, state_next;

    logic       m_valid_reg;
    lptd_out_t  m_data_reg;

    logic in_acc;
    logic keep_e;
    logic keep_mu;

    // Shared multiplier.
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] mul_prod;

    // Rotation unit.
    lptd_rot_cmd_t          rot_cmd;
    logic                   rot_done;
    logic signed [XY_W-1:0] rot_x;
    logic signed [XY_W-1:0] rot_y;

    // Square root unit.
    logic              root_start;
    logic [SUM_W-1:0]  root_in;
    logic              root_done;
    logic [ROOT_W-1:0] root_val;

    logic signed [XY_W-1:0] dx;
    logic [LEN_W-1:0]       len_rnd;
    logic [DIFF_W-1:0]      len_sat;
    logic                   out_load;

    assign in_acc    = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    // Quality is compared as a plain unsigned number against the cut.
    assign keep_e  = !s_data.is_muon && (s_data.quality > e_cut_reg) &&
                     (!have_e_reg || (s_data.momentum > e_mom_reg));
    assign keep_mu = s_data.is_muon && (s_data.quality > mu_cut_reg) &&
                     (!have_mu_reg || (s_data.momentum > mu_mom_reg));

    // Leaders after the current item is taken into account.
    always_comb begin
        e_mom_next   = e_mom_reg;
        e_az_next    = e_az_reg;
        have_e_next  = have_e_reg;
        mu_mom_next  = mu_mom_reg;
        mu_az_next   = mu_az_reg;
        have_mu_next = have_mu_reg;
        if (keep_e) begin
            e_mom_next  = s_data.momentum;
            e_az_next   = s_data.azimuth;
            have_e_next = 1'b1;
        end
        if (keep_mu) begin
            mu_mom_next  = s_data.momentum;
            mu_az_next   = s_data.azimuth;
            have_mu_next = 1'b1;
        end
    end

    // Electron vector minus rotated muon vector; the y part is minus the rotated y, which squares the same.
    assign dx = XY_W'({w_e_mom_reg, {FRAC_BITS{1'b0}}}) - rot_x;

    // Round the root back to whole momentum steps and saturate.
    assign len_rnd = LEN_W'((({1'b0, root_val}) + (ROOT_W + 1)'(1 << (FRAC_BITS - 1)))
                            >> FRAC_BITS);
    assign len_sat = (len_rnd > LEN_W'(DIFF_MAX)) ? DIFF_MAX : len_rnd[DIFF_W-1:0];

    // Sequencer: next state and the controls of the shared units.
    always_comb begin
        state_next    = state_reg;
        mul_a         = '0;
        mul_b         = '0;
        rot_cmd       = '0;
        rot_cmd.quad  = w_theta_reg[AZ_W-1 -: 2];
        rot_cmd.mag   = mul_prod[FRAC_BITS +: MAG_W];
        rot_cmd.angle = w_theta_reg[ANG_W-1:0];
        root_start    = 1'b0;
        root_in       = sum_reg + mul_prod[SUM_W-1:0];
        out_load      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc && s_data.end_of_event) begin
                    state_next = (have_e_next && have_mu_next) ? ST_SCALE : ST_DONE;
                end
            end
            ST_SCALE: begin
                // Prescale the muon momentum by the inverse rotation gain.
                mul_a      = MUL_W'({1'b0, w_mu_mom_reg});
                mul_b      = INV_GAIN;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                rot_cmd.start = 1'b1;
                state_next    = ST_ROTATE;
            end
            ST_ROTATE: begin
                if (rot_done) begin
                    state_next = ST_SQ_X;
                end
            end
            ST_SQ_X: begin
                mul_a      = dx;
                mul_b      = dx;
                state_next = ST_SQ_Y;
            end
            ST_SQ_Y: begin
                mul_a      = rot_y;
                mul_b      = rot_y;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                root_start = 1'b1;
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                if (root_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            e_cut_reg   <= ELECTRON_CUT_RESET;
            mu_cut_reg  <= MUON_CUT_RESET;
            e_mom_reg   <= '0;
            e_az_reg    <= '0;
            have_e_reg  <= 1'b0;
            mu_mom_reg  <= '0;
            mu_az_reg   <= '0;
            have_mu_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_ELECTRON_CUT: e_cut_reg  <= cfg_data[QUAL_W-1:0];
                    CFG_MUON_CUT:     mu_cut_reg <= cfg_data[QUAL_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (in_acc) begin
                if (s_data.end_of_event) begin
                    // The event's leaders move to the work registers.
                    e_mom_reg   <= '0;
                    e_az_reg    <= '0;
                    have_e_reg  <= 1'b0;
                    mu_mom_reg  <= '0;
                    mu_az_reg   <= '0;
                    have_mu_reg <= 1'b0;
                end else begin
                    e_mom_reg   <= e_mom_next;
                    e_az_reg    <= e_az_next;
                    have_e_reg  <= have_e_next;
                    mu_mom_reg  <= mu_mom_next;
                    mu_az_reg   <= mu_az_next;
                    have_mu_reg <= have_mu_next;
                end
            end

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end

        if (in_acc && s_data.end_of_event) begin
            w_e_mom_reg  <= e_mom_next;
            w_mu_mom_reg <= mu_mom_next;
            w_theta_reg  <= mu_az_next - e_az_next;
            w_def_reg    <= have_e_next && have_mu_next;
        end

        // Square of dx arrives while dy is being squared.
        if (state_reg == ST_SQ_Y) begin
            sum_reg <= mul_prod[SUM_W-1:0];
        end

        if (out_load) begin
            m_data_reg.momentum_difference <= w_def_reg ? len_sat : '0;
            m_data_reg.defined             <= w_def_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    lptd_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_prod)
    );

    lptd_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (rot_cmd),
        .done    (rot_done),
        .x_out   (rot_x),
        .y_out   (rot_y)
    );

    lptd_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (root_start),
        .radicand (root_in),
        .done     (root_done),
        .root     (root_val)
    );

    // The rotation unit only finishes while the sequencer waits for it.
    `ASSERT_ALWAYS(a_rot_done_in_rotate, aclk, aresetn,
        !rot_done || (state_reg == ST_ROTATE), "rotation finished outside its wait state")

    // The root unit only finishes while the sequencer waits for it.
    `ASSERT_ALWAYS(a_root_done_in_root, aclk, aresetn,
        !root_done || (state_reg == ST_ROOT), "square root finished outside its wait state")

    // A result without both kinds carries a zero difference.
    `ASSERT_ALWAYS(a_undefined_is_zero, aclk, aresetn,
        !m_valid || m_data.defined || (m_data.momentum_difference == '0),
        "undefined result with nonzero difference")

    // The difference never exceeds its saturation value.
    `ASSERT_ALWAYS(a_diff_saturated, aclk, aresetn,
        !m_valid || (m_data.momentum_difference <= DIFF_MAX), "difference above saturation")

    // Ending an event clears both leaders.
    `ASSERT_NEXT(a_event_end_clears, aclk, aresetn, in_acc && s_data.end_of_event,
        !have_e_reg && !have_mu_reg, "leaders not cleared at event end")

endmodule
